// ===== rtl/core/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit checker.
// No dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rau check failed");
`endif

// ===== rtl/core/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes, relation codes, states.
// No dependencies.
package rau_pkg;
    localparam int OUT_W = 34;
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_CMP = 3'd4;
    localparam logic [1:0] REL_AGT = 2'd0;
    localparam logic [1:0] REL_BGT = 2'd1;
    localparam logic [1:0] REL_EQ  = 2'd2;
    localparam logic [1:0] REL_NONE = 2'd3;
    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_COMB, ST_CHK,
        ST_GSHIFT, ST_GODD, ST_GLOOP, ST_DIVN, ST_DIVD, ST_DONE
    } t_state;
endpackage

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: bit-serial multiplier, binary gcd, serial divider.
// Depends on rau_pkg.
//
// One transaction in, one transaction out. Each item runs sequentially on one
// serial datapath: three shift-add products (one multiplier bit per cycle),
// a binary gcd stepping one shift or subtract per cycle, then two restoring
// divisions at one quotient bit per cycle. Compare and unused codes skip the gcd
// and divisions, as does a result whose parts are both negative or below 2, and a
// result with one zero part skips the gcd and divides by the other part's
// magnitude. Products are formed modulo 2^64 and results truncated to 34 bits.
// The input is ready only in the idle state; a result waits in the output
// registers until taken.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_func,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [OUT_W-1:0]         o_res_num,
    output logic signed [OUT_W-1:0]         o_res_den,
    output logic [1:0]                      o_relation
);
    t_state r_state, n_state;
    logic [2:0]  r_func;
    logic [63:0] r_an, r_ad, r_bn, r_bd;
    // serial multiplier
    logic [63:0] r_mc, r_mp, r_acc;
    logic [5:0]  r_cnt;
    logic [63:0] r_p1, r_p2, r_num, r_den;
    // gcd
    logic [63:0] r_ga, r_gb;
    logic [5:0]  r_k;
    // divider
    logic [63:0] r_q, r_rem, r_g;
    logic        r_ovalid;
    logic [1:0]  r_rel;
    logic        same_den;
    logic [63:0] mag_num, mag_den, gval, sub_v;
    logic [64:0] trial;

    assign same_den = (r_ad == r_bd);
    assign mag_num  = r_num[63] ? (64'd0 - r_num) : r_num;
    assign mag_den  = r_den[63] ? (64'd0 - r_den) : r_den;
    assign gval     = r_ga << r_k;
    assign trial    = {r_rem[63:0], r_q[63]} - {1'b0, r_g};
    assign sub_v    = r_gb - r_ga;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid && o_ready) n_state = ST_MUL1;
            ST_MUL1, ST_MUL2, ST_MUL3: if (r_cnt == 6'd63) begin
                n_state = (r_state == ST_MUL1) ? ST_MUL2 :
                          (r_state == ST_MUL2) ? ST_MUL3 : ST_COMB;
            end
            ST_COMB:   n_state = ST_CHK;
            ST_CHK:    n_state = ST_GSHIFT;
            ST_GSHIFT: if (r_ga[0] || r_gb[0]) n_state = ST_GODD;
            ST_GODD:   if (r_ga[0]) n_state = ST_GLOOP;
            ST_GLOOP:  if (r_gb == 64'd0) n_state = ST_DIVN;
            ST_DIVN, ST_DIVD: if (r_cnt == 6'd63)
                n_state = (r_state == ST_DIVN) ? ST_DIVD : ST_DONE;
            ST_DONE:   if (!r_ovalid) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
        // arithmetic that needs no reduction, compare, unused codes
        if (r_state == ST_CHK) begin
            if (r_func > FUNC_DIV) n_state = ST_DONE;
            else if ((r_num[63] || r_num < 64'd2) && (r_den[63] || r_den < 64'd2))
                n_state = ST_DONE;
            // one zero part: the gcd is the other part's magnitude
            else if (mag_num == 64'd0 || mag_den == 64'd0) n_state = ST_DIVN;
        end
        if (r_state == ST_GLOOP && r_gb == 64'd0 && gval < 64'd2) n_state = ST_DONE;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (i_valid && o_ready) begin
                r_func <= i_func;
                r_an <= 64'(i_a_num); r_ad <= 64'(i_a_den);
                r_bn <= 64'(i_b_num); r_bd <= 64'(i_b_den);
                // first product: an*bd
                r_mc <= 64'(i_a_num); r_mp <= 64'(i_b_den);
                r_acc <= '0; r_cnt <= '0;
            end
            ST_MUL1, ST_MUL2, ST_MUL3: begin
                // one multiplier bit per cycle
                if (r_cnt == 6'd63) begin
                    r_cnt <= '0; r_acc <= '0;
                    if (r_state == ST_MUL1) begin
                        r_p1 <= r_acc + (r_mp[0] ? r_mc : 64'd0);
                        // second: bn*ad (add/sub), an*bn (mul), ad*bn (div, cmp)
                        r_mc <= (r_func == FUNC_MUL) ? r_an : r_ad;
                        r_mp <= r_bn;
                    end else if (r_state == ST_MUL2) begin
                        r_p2 <= r_acc + (r_mp[0] ? r_mc : 64'd0);
                        r_mc <= r_ad; r_mp <= r_bd;
                    end else r_den <= r_acc + (r_mp[0] ? r_mc : 64'd0);
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                    r_acc <= r_acc + (r_mp[0] ? r_mc : 64'd0);
                    r_mc <= r_mc << 1; r_mp <= r_mp >> 1;
                end
            end
            ST_COMB: begin
                r_rel <= REL_NONE;
                case (r_func)
                    FUNC_ADD, FUNC_SUB: begin
                        if (same_den) begin
                            r_num <= (r_func == FUNC_ADD) ? r_an + r_bn : r_an - r_bn;
                            r_den <= r_ad;
                        end else
                            r_num <= (r_func == FUNC_ADD) ? r_p1 + r_p2 : r_p1 - r_p2;
                    end
                    FUNC_MUL: r_num <= r_p2;
                    FUNC_DIV: begin r_num <= r_p1; r_den <= r_p2; end
                    FUNC_CMP: begin
                        r_num <= '0; r_den <= '0;
                        if ($signed(r_p2) < $signed(r_p1)) r_rel <= REL_AGT;
                        else if ($signed(r_p1) < $signed(r_p2)) r_rel <= REL_BGT;
                        else r_rel <= REL_EQ;
                    end
                    default: begin r_num <= '0; r_den <= '0; end
                endcase
            end
            ST_CHK: begin
                r_ga <= mag_num; r_gb <= mag_den; r_k <= '0;
                // divider setup for the zero-part path; the gcd path sets it again
                r_g <= mag_num | mag_den; r_q <= mag_num; r_rem <= '0; r_cnt <= '0;
            end
            ST_GSHIFT: if (!(r_ga[0] || r_gb[0])) begin
                r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_k <= r_k + 6'd1;
            end
            ST_GODD: if (!r_ga[0]) r_ga <= r_ga >> 1;
            ST_GLOOP: begin
                if (r_gb == 64'd0) begin
                    r_g <= gval; r_q <= mag_num; r_rem <= '0; r_cnt <= '0;
                end else if (!r_gb[0]) r_gb <= r_gb >> 1;
                else if (r_ga > r_gb) begin r_ga <= r_gb; r_gb <= r_ga - r_gb; end
                else r_gb <= sub_v;
            end
            ST_DIVN, ST_DIVD: begin
                // restoring division, one quotient bit per cycle
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63 && r_state == ST_DIVN) begin
                    r_num <= r_num[63] ? 64'd0 - {r_q[62:0], ~trial[64]}
                                       : {r_q[62:0], ~trial[64]};
                    r_q <= mag_den; r_rem <= '0;
                end else begin
                    if (!trial[64]) begin
                        r_rem <= trial[63:0]; r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_q[63]}; r_q <= {r_q[62:0], 1'b0};
                    end
                    if (r_cnt == 6'd63)
                        r_den <= r_den[63] ? 64'd0 - {r_q[62:0], ~trial[64]}
                                           : {r_q[62:0], ~trial[64]};
                end
            end
            default: ;
        endcase
        if (r_state == ST_DONE && !r_ovalid) begin
            o_res_num <= r_num[OUT_W-1:0];
            o_res_den <= r_den[OUT_W-1:0];
            o_relation <= r_rel;
        end
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (r_state == ST_DONE && !r_ovalid) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;
    end

    assign o_valid = r_ovalid;
    assign o_ready = (r_state == ST_IDLE);
endmodule

// ===== rtl/core/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_assert.svh.
`include "rational_arithmetic_unit_assert.svh"
module rau_checker import rau_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [OUT_W-1:0]  o_res_num,
    input logic [1:0]        o_relation
);
    `RAU_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_res_num))
    `RAU_ASSERT(a_busy, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)
    `RAU_ASSERT(a_cmp0, i_clk, i_rst_n, o_valid && o_relation != REL_NONE |-> o_res_num == '0)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_res_num(o_res_num),
    .o_relation(o_relation)
);

// ===== tb/tb.sv =====
// Self-checking testbench for rational_arithmetic_unit: directed table, then random fractions.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 100ps

module tb;
    import rau_pkg::*;

    localparam int N_RANDOM = 830;
    localparam int IDLE_LIMIT = 20000;  // covers the worst item plus a long stall

    typedef struct packed {
        logic [OUT_W-1:0] num;
        logic [OUT_W-1:0] den;
        logic [1:0]       rel;
    } t_fraction;

    // Directed row: known = 1 means the expected result is typed in here.
    typedef struct packed {
        logic             known;
        logic [2:0]       func;
        logic [15:0]      an;
        logic [15:0]      ad;
        logic [15:0]      bn;
        logic [15:0]      bd;
        logic [OUT_W-1:0] num;
        logic [OUT_W-1:0] den;
        logic [1:0]       rel;
    } t_stim_row;

    localparam int N_ROWS = 22;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        // same denominator add, reduces 2/2 to 1/1
        '{1'b1, FUNC_ADD, 16'd1, 16'd2, 16'd1, 16'd2, 34'd1, 34'd1, REL_NONE},
        '{1'b0, FUNC_ADD, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 34'd0, 34'd0, REL_NONE},
        '{1'b0, FUNC_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 34'd0, 34'd0, REL_NONE},
        '{1'b0, FUNC_SUB, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 34'd0, 34'd0, REL_NONE},
        '{1'b0, FUNC_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 34'd0, 34'd0, REL_NONE},
        // (-2^15)^2 over itself reduces to 1/1
        '{1'b1, FUNC_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 34'd1, 34'd1, REL_NONE},
        '{1'b0, FUNC_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 34'd0, 34'd0, REL_NONE},
        '{1'b0, FUNC_DIV, 16'hffff, 16'h0003, 16'h0006, 16'hfffe, 34'd0, 34'd0, REL_NONE},
        // zero denominators: 8/0 reduces by 8 to 1/0
        '{1'b1, FUNC_ADD, 16'd3, 16'd0, 16'd5, 16'd0, 34'd1, 34'd0, REL_NONE},
        '{1'b0, FUNC_SUB, 16'd7, 16'd0, 16'd9, 16'd3, 34'd0, 34'd0, REL_NONE},
        // both parts zero stay zero
        '{1'b1, FUNC_MUL, 16'd0, 16'd0, 16'd5, 16'd7, 34'd0, 34'd0, REL_NONE},
        // negative maximum: -4/-6 is left unreduced
        '{1'b1, FUNC_MUL, -16'sd2, -16'sd3, 16'd2, 16'd2, -34'sd4, -34'sd6, REL_NONE},
        '{1'b0, FUNC_DIV, 16'd0, 16'd0, 16'd0, 16'd0, 34'd0, 34'd0, REL_NONE},
        '{1'b1, FUNC_CMP, 16'd1, 16'd2, 16'd1, 16'd2, 34'd0, 34'd0, REL_EQ},
        '{1'b1, FUNC_CMP, 16'd1, 16'd1, 16'd0, 16'd1, 34'd0, 34'd0, REL_AGT},
        '{1'b1, FUNC_CMP, 16'd0, 16'd1, 16'd1, 16'd1, 34'd0, 34'd0, REL_BGT},
        '{1'b0, FUNC_CMP, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 34'd0, 34'd0, REL_NONE},
        '{1'b0, FUNC_CMP, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 34'd0, 34'd0, REL_NONE},
        // unused selectors
        '{1'b1, 3'd5, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 34'd0, 34'd0, REL_NONE},
        '{1'b1, 3'd6, 16'd1, 16'd2, 16'd3, 16'd4, 34'd0, 34'd0, REL_NONE},
        '{1'b1, 3'd7, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 34'd0, 34'd0, REL_NONE},
        '{1'b0, FUNC_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 34'd0, 34'd0, REL_NONE}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [2:0]        i_func;
    logic signed [15:0] i_a_num;
    logic signed [15:0] i_a_den;
    logic signed [15:0] i_b_num;
    logic signed [15:0] i_b_den;
    logic              o_valid;
    logic              i_ready;
    logic signed [OUT_W-1:0] o_res_num;
    logic signed [OUT_W-1:0] o_res_den;
    logic [1:0]        o_relation;

    t_fraction pending_results [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        stimulus_done = 0;

    rational_arithmetic_unit #(.OPERAND_WIDTH(16)) uut (.*);

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Binary gcd on 64-bit magnitudes.
    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        int          shift;
        logic [63:0] t;
        shift = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 64'd1) == 0) begin
            x = x >> 1;
            y = y >> 1;
            shift++;
        end
        while (x[0] == 1'b0) x = x >> 1;
        while (y != 0) begin
            while (y[0] == 1'b0) y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << shift;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // Compute the reduced fraction (or relation) for one operation, modulo 2^64.
    function automatic t_fraction predict_fraction(input logic [2:0] func,
            input logic [15:0] an16, input logic [15:0] ad16,
            input logic [15:0] bn16, input logic [15:0] bd16);
        logic [63:0] an, ad, bn, bd, num, den, lhs, rhs, big, g, q;
        logic [1:0]  rel;
        bit          arith;
        t_fraction   r;
        an = {{48{an16[15]}}, an16};
        ad = {{48{ad16[15]}}, ad16};
        bn = {{48{bn16[15]}}, bn16};
        bd = {{48{bd16[15]}}, bd16};
        num = 0;
        den = 0;
        rel = REL_NONE;
        arith = 1;
        case (func)
            FUNC_ADD, FUNC_SUB: begin
                if (ad == bd) begin
                    num = (func == FUNC_ADD) ? an + bn : an - bn;
                    den = ad;
                end else begin
                    lhs = an * bd;
                    rhs = bn * ad;
                    num = (func == FUNC_ADD) ? lhs + rhs : lhs - rhs;
                    den = ad * bd;
                end
            end
            FUNC_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            FUNC_DIV: begin
                num = an * bd;
                den = ad * bn;
            end
            FUNC_CMP: begin
                lhs = an * bd;
                rhs = ad * bn;
                if ($signed(rhs) < $signed(lhs)) rel = REL_AGT;
                else if ($signed(lhs) < $signed(rhs)) rel = REL_BGT;
                else rel = REL_EQ;
                arith = 0;
            end
            default: arith = 0;
        endcase
        if (arith) begin
            big = ($signed(num) < $signed(den)) ? den : num;
            if (!($signed(big) < 64'sd2)) begin
                g = gcd64(abs64(num), abs64(den));
                if (g >= 2) begin
                    q = abs64(num) / g;
                    num = num[63] ? -q : q;
                    q = abs64(den) / g;
                    den = den[63] ? -q : q;
                end
            end
        end
        r.num = num[OUT_W-1:0];
        r.den = den[OUT_W-1:0];
        r.rel = rel;
        return r;
    endfunction

    // Mostly zero, sometimes short, rarely a long stall.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Hold a transaction on the input until accepted, then queue its result.
    task automatic send_fraction(input logic [2:0] func, input logic [15:0] an,
            input logic [15:0] ad, input logic [15:0] bn, input logic [15:0] bd,
            input bit known, input t_fraction typed);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_func  <= func;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(known ? typed : predict_fraction(func, an, ad, bn, bd));
    endtask

    // Random operand: full range, small values, or near the extremes.
    function automatic logic [15:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($urandom);
        if (r < 8) return 16'($urandom_range(0, 24) - 12);
        return $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 3))
                                    : 16'h7fff - 16'($urandom_range(0, 3));
    endfunction

    initial begin
        t_fraction   typed;
        logic [2:0]  func;
        logic [15:0] an, ad, bn, bd;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func  = '0;
        i_a_num = '0;
        i_a_den = '0;
        i_b_num = '0;
        i_b_den = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        foreach (DIRECTED[k]) begin
            typed.num = DIRECTED[k].num;
            typed.den = DIRECTED[k].den;
            typed.rel = DIRECTED[k].rel;
            send_fraction(DIRECTED[k].func, DIRECTED[k].an, DIRECTED[k].ad,
                          DIRECTED[k].bn, DIRECTED[k].bd, DIRECTED[k].known, typed);
        end

        // Random fractions; share denominators often so the same-denominator path gets hit.
        typed = '0;
        for (int n = 0; n < N_RANDOM; n++) begin
            func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            an = pick_operand();
            ad = pick_operand();
            bn = pick_operand();
            bd = ($urandom_range(0, 3) == 0) ? ad : pick_operand();
            if (func == FUNC_CMP && $urandom_range(0, 3) == 0) begin
                bn = an;
                bd = ad;
            end
            send_fraction(func, an, ad, bn, bd, 1'b0, typed);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        stimulus_done = 1;
    end

    // Result side backpressure: drop ready for random stretches.
    initial begin
        int gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result num=%0d den=%0d rel=%0d",
                         $time, o_res_num, o_res_den, o_relation);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res_num !== want.num) begin
                    $display("%0t: res_num expected %0d actual %0d",
                             $time, $signed(want.num), o_res_num);
                    error_count++;
                end
                if (o_res_den !== want.den) begin
                    $display("%0t: res_den expected %0d actual %0d",
                             $time, $signed(want.den), o_res_den);
                    error_count++;
                end
                if (o_relation !== want.rel) begin
                    $display("%0t: relation expected %0d actual %0d",
                             $time, want.rel, o_relation);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: advance only while no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Verification failed");
            $finish;
        end
    end

    // Drain, then let the block settle before the verdict.
    initial begin
        wait (stimulus_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
